/* sv/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned GroupW   = 24;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned HeldW    = 16;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;

  localparam logic [7:0] PadChar   = 8'h3d;
  localparam logic [1:0] LastIdx   = 2'd3;

  // one gathered group handed from the front to the back
  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [1:0]        filled;  // bytes in the group, 1..3
    logic              fin;     // group closes the message
  } grp_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  function automatic logic [7:0] sym_lookup(input logic [SextetW-1:0] idx);
    logic [7:0] ch;
    if (idx < 6'd26) begin
      ch = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      ch = 8'h61 + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      ch = 8'h30 + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      ch = 8'h2b;
    end else begin
      ch = 8'h2f;
    end
    return ch;
  endfunction

endpackage

/* sv/base64_encoder.sv */
// ----------------------------------------------------------------------------
// base64_encoder
// Streaming base64 encoder: bytes in, four characters per 24-bit group out.
// ----------------------------------------------------------------------------
// The byte that closes a group is written to the queue, loaded into the group
//   register and its first character registered in the single output register.
// Throughput: one character per cycle while the sink is ready; a 2-group queue absorbs bursts.
// Reset: async active low, clears held bytes, queue and output valid.
module base64_encoder
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // is_final
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] code_char
  output logic       m_axis_tlast    // end_of_text
);

  logic push, pop, q_full, q_empty;
  grp_t push_grp, head;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_fin_i   (s_axis_tlast),
    .push_o     (push),
    .push_grp_o (push_grp),
    .q_full_i   (q_full)
  );

  b64e_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* sv/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Gathers incoming bytes into 24-bit groups and pushes closed groups.
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_fin_i,
  output logic             push_o,
  output grp_t             push_grp_o,
  input  logic             q_full_i
);

  logic [HeldW-1:0]  held_q, held_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [GroupW-1:0] group;
  logic [1:0]        filled;
  logic              accept;
  logic              close;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (cnt_q)
      2'd1:    group = {held_q[15:8], in_byte_i, 8'h00};
      2'd2:    group = {held_q, in_byte_i};
      default: group = {in_byte_i, 16'h0000};
    endcase
    filled = (cnt_q == 2'd1) ? 2'd2 : (cnt_q == 2'd2) ? 2'd3 : 2'd1;
    close  = in_fin_i || (filled == 2'd3);
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (close) begin
        held_d = '0;
        cnt_d  = 2'd0;
      end else begin
        held_d = group[GroupW-1:8];
        cnt_d  = filled;
      end
    end
  end

  assign push_o     = accept && close;
  assign push_grp_o = '{group: group, filled: filled, fin: in_fin_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= 2'd0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* sv/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry group queue between the gathering front and the character back.
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t push_grp_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output grp_t head_o
);

  grp_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("group queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("group queue popped while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("group queue count out of range");

endmodule

/* sv/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Turns each queued group into four characters, one per cycle while the output is not stalled, with padding.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  grp_t             q_head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_char_o,
  output logic             out_last_o
);

  grp_t             cur_q;
  logic             busy_q;
  logic [1:0]       idx_q;
  logic             ovalid_q;
  logic [ByteW-1:0] ochar_q, ochar_d;
  logic             olast_q;
  logic             emit;
  logic [SextetW-1:0] sextet;

  // output slot free this cycle
  assign emit  = busy_q && (!ovalid_q || out_ready_i);
  assign pop_o = !q_empty_i && (!busy_q || (emit && idx_q == LastIdx));

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = cur_q.group[23:18];
      2'd1:    sextet = cur_q.group[17:12];
      2'd2:    sextet = cur_q.group[11:6];
      default: sextet = cur_q.group[5:0];
    endcase
    ochar_d = sym_lookup(sextet);
    if (cur_q.fin && (idx_q > cur_q.filled)) ochar_d = PadChar;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_head_i;
    if (emit) begin
      ochar_q <= ochar_d;
      olast_q <= cur_q.fin && (idx_q == LastIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
        idx_q    <= idx_q + 2'd1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && idx_q == LastIdx) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> idx_q == 2'd0)
    else $error("character index moved while idle");
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && idx_q == LastIdx && cur_q.fin) |=> (ovalid_q && olast_q))
    else $error("closing character lost its last flag");
  a_pop_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pop_o) |-> (emit && idx_q == LastIdx))
    else $error("group loaded over an unfinished one");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// base64_encoder testbench
// Streams byte messages into the encoder and checks every character against
// a local model of the encoder. The model tracks the partial group and padding.
// Random gaps on the input and random stalls on the output run in most phases; one phase runs at full rate.
// ----------------------------------------------------------------------------
module testbench
  import b64e_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 12;
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic [0:0] {TX_RANDOM, TX_BACK_TO_BACK} tx_mode_e;
  typedef enum logic [1:0] {RX_RANDOM, RX_ALWAYS, RX_HEAVY} rx_mode_e;

  typedef struct {
    logic [7:0] code_char;
    logic       end_of_text;
  } b64_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;    // is_final
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] code_char
  logic       m_axis_tlast;           // end_of_text

  // encoder model state
  logic [15:0] open_group_bytes = 16'h0000;
  logic [1:0]  open_group_count = 2'd0;
  b64_char_t   pending_chars[$];

  tx_mode_e    tx_mode = TX_RANDOM;
  rx_mode_e    rx_mode = RX_RANDOM;
  int unsigned stall_left = 0;
  int unsigned rx_roll;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned final_chars = 0;
  b64_char_t   got_char;

  base64_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d characters still pending",
             cycle_count, pending_chars.size());
    $display("Verification failed");
    $finish;
  end

  // Folds one accepted byte into the open group; emits four characters once
  // the group is full or the message ends.
  function automatic void encode_byte(input logic [7:0] data_byte, input logic is_final);
    logic [23:0] group;
    int unsigned filled;
    logic [5:0]  idx;
    b64_char_t   ch;
    case (open_group_count)
      2'd1:    group = {open_group_bytes[15:8], data_byte, 8'h00};
      2'd2:    group = {open_group_bytes, data_byte};
      default: group = {data_byte, 16'h0000};
    endcase
    filled = (open_group_count == 2'd3) ? 1 : open_group_count + 1;
    if (filled < 3 && !is_final) begin
      open_group_bytes = group[23:8];
      open_group_count = filled[1:0];
      return;
    end
    for (int k = 0; k < 4; k++) begin
      idx = group[6*(3-k) +: 6];
      ch.code_char = Alphabet[8*(63-idx) +: 8];
      // chars past the real bytes of a short final group become padding
      if (is_final && k > filled) ch.code_char = PadChar;
      ch.end_of_text = is_final && (k == 3);
      pending_chars = {pending_chars, ch};
    end
    open_group_bytes = 16'h0000;
    open_group_count = 2'd0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) encode_byte(s_axis_tdata, s_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: code_char %h end_of_text %b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        got_char = pending_chars.pop_front();
        chars_checked++;
        if (got_char.end_of_text) final_chars++;
        if (m_axis_tdata !== got_char.code_char) begin
          $error("code_char: expected %h, got %h", got_char.code_char, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== got_char.end_of_text) begin
          $error("end_of_text: expected %b, got %b", got_char.end_of_text, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // output side: random mode is mostly ready, short stalls, now and then a long one; heavy mode stalls long and often
  always @(posedge clk_i) begin
    if (rx_mode == RX_ALWAYS) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < ((rx_mode == RX_HEAVY) ? 40 : 70)) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = (rx_mode == RX_HEAVY || rx_roll >= 97) ? $urandom_range(10, 40)
                                                            : $urandom_range(0, 3);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_mode == TX_BACK_TO_BACK) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] data_byte, input logic is_final);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data_byte;
    s_axis_tlast  <= is_final;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
    messages_sent++;
  endtask

  task automatic send_messages(input int unsigned byte_budget);
    int unsigned start;
    int unsigned len;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 9);
      send_message(len);
    end
  endtask

  // padding on one and two byte tails, full groups, '+' and '/', and a short
  // message right after a full one so stale held bits would show
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbe, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h4d, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6e, 1'b0);
    send_byte(8'h4d, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    messages_sent += 8;
  endtask

  task automatic test_random_messages();
    tx_mode = TX_RANDOM;
    rx_mode = RX_RANDOM;
    send_messages(40);
  endtask

  task automatic test_full_rate();
    tx_mode = TX_BACK_TO_BACK;
    rx_mode = RX_ALWAYS;
    send_messages(15);
  endtask

  task automatic test_backpressure();
    tx_mode = TX_BACK_TO_BACK;
    rx_mode = RX_HEAVY;
    send_messages(8);
    tx_mode = TX_RANDOM;
    send_messages(8);
  endtask

  initial begin : main
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_messages();
    test_full_rate();
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    rx_mode = RX_RANDOM;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      $error("%0d characters never arrived", pending_chars.size());
      errors++;
    end
    $display("sent %0d bytes in %0d messages, checked %0d characters (%0d message ends)",
             bytes_sent, messages_sent, chars_checked, final_chars);
    $display("input gaps and output stalls random, plus full-rate and heavy-stall phases");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
